### rtl/jkpb_pkg.sv
package jkpb_pkg;

	localparam int COORD_BITS = 24;
	localparam int MARK_BITS = 24;
	localparam int U_BITS = 50;
	localparam int LOG_BITS = 23;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 32;

	// Squared-distance epsilon in Q.24
	localparam logic [U_BITS-1:0] EPS_Q24 = 50'd17;

	localparam logic [1:0] FUNC_ACCUM = 2'd0;
	localparam logic [1:0] FUNC_READ = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;
	localparam logic [1:0] FUNC_NOP = 2'd3;

	localparam logic [CFG_IDX_BITS-1:0] REG_BOX_LENGTH = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_REGIONS_PER_SIDE = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_REGION_SCALE = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_NUM_BINS = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_BIN_SCALE = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_BIN_OFFSET = 3'd5;

	localparam logic [23:0] RST_BOX_LENGTH = 24'd4194304;
	localparam logic [2:0] RST_REGIONS_PER_SIDE = 3'd4;
	localparam logic [31:0] RST_REGION_SCALE = 32'd16777216;
	localparam logic [4:0] RST_NUM_BINS = 5'd11;
	localparam logic signed [23:0] RST_BIN_SCALE = 24'sd51671;
	localparam logic signed [23:0] RST_BIN_OFFSET = -24'sd102985;

	typedef struct packed {
		logic [1:0] func;
		logic [COORD_BITS-1:0] first_x;
		logic [COORD_BITS-1:0] first_y;
		logic [COORD_BITS-1:0] first_z;
		logic signed [MARK_BITS-1:0] first_mark;
		logic [COORD_BITS-1:0] second_x;
		logic [COORD_BITS-1:0] second_y;
		logic [COORD_BITS-1:0] second_z;
		logic signed [MARK_BITS-1:0] second_mark;
		logic [5:0] read_region;
		logic [3:0] read_bin;
	} req_t;

	typedef struct packed {
		logic [5:0] out_region;
		logic [3:0] out_bin;
		logic signed [63:0] weighted_sum;
	} rsp_t;

endpackage

### rtl/jkpb_log2.sv
// Fixed point log2(u) - 24 in Q.16: binary-search normalize, then 16 squarings
module jkpb_log2 (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [63:0] u,
	output logic done,
	output logic signed [jkpb_pkg::LOG_BITS-1:0] lg
);

	typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQ} phase_t;

	phase_t phase_q;
	logic [63:0] m_q;
	logic [5:0] msb_q;
	logic [2:0] k_q;
	logic [31:0] m32_q;
	logic [15:0] frac_q;
	logic [3:0] i_q;
	logic done_q;

	logic [6:0] sh;
	logic norm_hit;
	logic [63:0] m_next;
	logic [63:0] sq;
	logic [32:0] sq_t;
	logic [6:0] exp_w;

	// One normalize step: shift by 32, 16, ... 1 when the top bits are clear
	always_comb begin
		sh = 7'd1 << k_q;
		norm_hit = ((m_q >> (7'd64 - sh)) == 64'd0);
		m_next = norm_hit ? (m_q << sh) : m_q;
	end

	// One squaring step of the Q1.31 mantissa
	always_comb begin
		sq = 64'(m32_q) * 64'(m32_q);
		sq_t = sq[63:31];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= L_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				L_IDLE: begin
					if (start) begin
						m_q <= u;
						msb_q <= 6'd63;
						k_q <= 3'd5;
						phase_q <= L_NORM;
					end
				end
				L_NORM: begin
					m_q <= m_next;
					if (norm_hit) msb_q <= msb_q - 6'(sh);
					k_q <= k_q - 3'd1;
					if (k_q == 3'd0) begin
						m32_q <= m_next[63:32];
						frac_q <= 16'd0;
						i_q <= 4'd15;
						phase_q <= L_SQ;
					end
				end
				L_SQ: begin
					m32_q <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
					frac_q <= {frac_q[14:0], sq_t[32]};
					i_q <= i_q - 4'd1;
					if (i_q == 4'd0) begin
						done_q <= 1'b1;
						phase_q <= L_IDLE;
					end
				end
				default: phase_q <= L_IDLE;
			endcase
		end
	end

	assign exp_w = {1'b0, msb_q} - 7'd24;
	assign lg = {exp_w, frac_q};
	assign done = done_q;

endmodule

### rtl/jackknife_marked_pair_binner_core.sv
// Marked pair binner with jackknife regions.
// Request channel (req_valid / req_stall / req) carries one transaction: func 0
// accumulates a point pair, 1 reads a leave-one-out bin, 2 clears both
// histograms, 3 does nothing. Only a read produces a response on the
// rsp_valid / rsp_stall / rsp channel.
// Items are handled one at a time; req_stall is high while one is in work.
// Accumulate: a separation step, then the shared 33x33 multiplier forms three
// squares, three region products and the mark product, then the log2 unit
// runs (6 normalize steps, 16 squarings, start and hand-off), then a bin
// multiply, a bin step and, if the bin is in range, a read-modify-write of
// the histogram memories; the serial multiplier and log2 loop do most of the
// work for a pair. A read does a memory read, then waits for the response
// register if it is still full; a clear zeroes every histogram address.
// At reset the configuration registers take their defaults and a clearing
// pass over all MAX_REGIONS*MAX_BINS addresses zeroes the memories;
// requests stall meanwhile, configuration writes are taken at any time.
// A stalled response holds in its output register; the next request is still
// accepted, and a following read waits only if the register is still full.
module jackknife_marked_pair_binner_core #(
	parameter int MAX_REGIONS = 64,
	parameter int MAX_BINS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  jkpb_pkg::req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output jkpb_pkg::rsp_t rsp,
	input  logic cfg_we,
	input  logic [jkpb_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [jkpb_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	localparam int DEPTH = MAX_REGIONS * MAX_BINS;
	localparam int RA_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int TB_AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int CB = jkpb_pkg::COORD_BITS;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_SEP, S_MUL, S_LSTART, S_LWAIT,
		S_BMUL, S_BIN, S_RD, S_WR, S_QRD, S_QWAIT
	} state_t;

	// Configuration registers
	logic [23:0] box_q;
	logic [2:0] rps_q;
	logic [31:0] rs_q;
	logic [4:0] nbins_q;
	logic signed [23:0] bscale_q;
	logic signed [23:0] boff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= jkpb_pkg::RST_BOX_LENGTH;
			rps_q <= jkpb_pkg::RST_REGIONS_PER_SIDE;
			rs_q <= jkpb_pkg::RST_REGION_SCALE;
			nbins_q <= jkpb_pkg::RST_NUM_BINS;
			bscale_q <= jkpb_pkg::RST_BIN_SCALE;
			boff_q <= jkpb_pkg::RST_BIN_OFFSET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				jkpb_pkg::REG_BOX_LENGTH: box_q <= cfg_data[23:0];
				jkpb_pkg::REG_REGIONS_PER_SIDE: rps_q <= cfg_data[2:0];
				jkpb_pkg::REG_REGION_SCALE: rs_q <= cfg_data;
				jkpb_pkg::REG_NUM_BINS: nbins_q <= cfg_data[4:0];
				jkpb_pkg::REG_BIN_SCALE: bscale_q <= cfg_data[23:0];
				jkpb_pkg::REG_BIN_OFFSET: boff_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	state_t state_q;
	jkpb_pkg::req_t item_q;
	logic [CB-1:0] dx_q, dy_q, dz_q;
	logic [2:0] cnt_q;
	logic signed [65:0] prod_q;
	logic [jkpb_pkg::U_BITS-1:0] u_q;
	logic [5:0] reg_q;
	logic [63:0] mark_q;
	logic signed [46:0] bm_s1;
	logic [TB_AW-1:0] bin_q;
	logic [RA_AW-1:0] clr_q;
	logic rsp_valid_q;
	jkpb_pkg::rsp_t rsp_q;

	// Minimum-image separation along one axis
	function automatic logic [CB-1:0] axis_sep(input logic [CB-1:0] a, input logic [CB-1:0] b,
			input logic [23:0] box);
		logic [CB-1:0] d;
		logic [CB:0] bx;
		d = (a > b) ? (a - b) : (b - a);
		bx = (CB+1)'(box);
		if ({d, 1'b0} > {1'b0, bx}) begin
			d = (bx >= (CB+1)'(d)) ? CB'(bx - (CB+1)'(d)) : CB'((CB+1)'(d) - bx);
		end
		return d;
	endfunction

	// Effective counts
	logic [2:0] jk;
	logic [6:0] nb;
	always_comb begin
		if (rps_q == 3'd0) jk = 3'd1;
		else if (rps_q > 3'd4) jk = 3'd4;
		else jk = rps_q;
		nb = (32'(nbins_q) > MAX_BINS) ? 7'(MAX_BINS) : 7'(nbins_q);
	end

	// Shared multiplier operand select
	logic signed [32:0] mul_a, mul_b;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cnt_q)
			3'd0: begin mul_a = 33'(dx_q); mul_b = 33'(dx_q); end
			3'd1: begin mul_a = 33'(dy_q); mul_b = 33'(dy_q); end
			3'd2: begin mul_a = 33'(dz_q); mul_b = 33'(dz_q); end
			3'd3: begin mul_a = 33'(item_q.first_x); mul_b = {1'b0, rs_q}; end
			3'd4: begin mul_a = 33'(item_q.first_y); mul_b = {1'b0, rs_q}; end
			3'd5: begin mul_a = 33'(item_q.first_z); mul_b = {1'b0, rs_q}; end
			3'd6: begin
				mul_a = {{9{item_q.first_mark[23]}}, item_q.first_mark};
				mul_b = {{9{item_q.second_mark[23]}}, item_q.second_mark};
			end
			default: ;
		endcase
	end

	// Region axis index from the registered product, clamped to jk-1
	logic [11:0] axis_j;
	logic [1:0] axis_jc;
	logic [5:0] reg_next;
	always_comb begin
		axis_j = prod_q[55:44];
		axis_jc = (axis_j >= 12'(jk)) ? 2'(jk - 3'd1) : axis_j[1:0];
		reg_next = 6'(({3'b000, reg_q} * {6'b0, jk}) + 9'(axis_jc));
	end

	// Bin from the scaled log; floor via arithmetic shift
	logic signed [47:0] bin_t;
	logic signed [15:0] bin_w;
	logic bin_ok;
	always_comb begin
		bin_t = {bm_s1[46], bm_s1} - {{8{boff_q[23]}}, boff_q, 16'd0};
		bin_w = bin_t[47:32];
		bin_ok = !bin_w[15] && (bin_w < 16'(nb));
	end

	// Log2 unit
	logic lg_done;
	logic signed [jkpb_pkg::LOG_BITS-1:0] lg;
	jkpb_log2 u_log2 (
		.clk(clk),
		.arst_n(arst_n),
		.start(state_q == S_LSTART),
		.u(64'(u_q)),
		.done(lg_done),
		.lg(lg)
	);

	// Histogram memories and their port control
	logic [63:0] region_mem [DEPTH];
	logic [63:0] total_mem [MAX_BINS];
	logic [63:0] rg_rdata_q, tt_rdata_q;
	logic rg_we, tt_we;
	logic [RA_AW-1:0] rg_wa, rg_ra;
	logic [TB_AW-1:0] tt_wa, tt_ra;
	logic [63:0] rg_wd, tt_wd;

	logic q_reg_ok, q_bin_ok, a_reg_ok;
	logic [RA_AW-1:0] q_addr, a_addr;
	logic [6:0] q_bin_w;
	always_comb begin
		q_reg_ok = 32'(item_q.read_region) < MAX_REGIONS;
		q_bin_ok = 32'(item_q.read_bin) < MAX_BINS;
		q_bin_w = 7'(item_q.read_bin);
		q_addr = (q_reg_ok && q_bin_ok) ?
			RA_AW'(32'(item_q.read_region) * MAX_BINS + 32'(item_q.read_bin)) : '0;
		a_reg_ok = 32'(reg_q) < MAX_REGIONS;
		a_addr = a_reg_ok ? RA_AW'(32'(reg_q) * MAX_BINS + 32'(bin_q)) : '0;

		rg_ra = a_addr;
		tt_ra = bin_q;
		if (state_q == S_QRD || state_q == S_QWAIT) begin
			rg_ra = q_addr;
			tt_ra = q_bin_ok ? q_bin_w[TB_AW-1:0] : '0;
		end

		rg_we = 1'b0;
		tt_we = 1'b0;
		rg_wa = a_addr;
		tt_wa = bin_q;
		rg_wd = rg_rdata_q + mark_q;
		tt_wd = tt_rdata_q + mark_q;
		if (state_q == S_CLEAR) begin
			rg_we = 1'b1;
			tt_we = 32'(clr_q) < MAX_BINS;
			rg_wa = clr_q;
			tt_wa = TB_AW'(clr_q);
			rg_wd = '0;
			tt_wd = '0;
		end else if (state_q == S_WR) begin
			rg_we = a_reg_ok;
			tt_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rg_we) region_mem[rg_wa] <= rg_wd;
		rg_rdata_q <= region_mem[rg_ra];
	end

	always_ff @(posedge clk) begin
		if (tt_we) total_mem[tt_wa] <= tt_wd;
		tt_rdata_q <= total_mem[tt_ra];
	end

	// Leave-one-out value for a read
	logic [63:0] q_sum;
	assign q_sum = q_bin_ok ? (tt_rdata_q - (q_reg_ok ? rg_rdata_q : 64'd0)) : 64'd0;

	logic rsp_free;
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	// Sequencer and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			cnt_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && state_q != S_QWAIT) rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + RA_AW'(1);
					if (32'(clr_q) == DEPTH - 1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid) begin
						item_q <= req;
						unique case (req.func)
							jkpb_pkg::FUNC_ACCUM: state_q <= S_SEP;
							jkpb_pkg::FUNC_READ: state_q <= S_QRD;
							jkpb_pkg::FUNC_CLEAR: begin
								clr_q <= '0;
								state_q <= S_CLEAR;
							end
							jkpb_pkg::FUNC_NOP: state_q <= S_IDLE;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_SEP: begin
					dx_q <= axis_sep(item_q.first_x, item_q.second_x, box_q);
					dy_q <= axis_sep(item_q.first_y, item_q.second_y, box_q);
					dz_q <= axis_sep(item_q.first_z, item_q.second_z, box_q);
					u_q <= jkpb_pkg::EPS_Q24;
					reg_q <= '0;
					cnt_q <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q <= mul_a * mul_b;
					cnt_q <= cnt_q + 3'd1;
					// consume the product of the previous step
					case (cnt_q)
						3'd1, 3'd2, 3'd3: u_q <= u_q + jkpb_pkg::U_BITS'(prod_q[47:0]);
						3'd4, 3'd5, 3'd6: reg_q <= reg_next;
						3'd7: begin
							mark_q <= prod_q[63:0];
							state_q <= S_LSTART;
						end
						default: ;
					endcase
				end
				S_LSTART: state_q <= S_LWAIT;
				S_LWAIT: begin
					if (lg_done) state_q <= S_BMUL;
				end
				S_BMUL: begin
					bm_s1 <= lg * bscale_q;
					state_q <= S_BIN;
				end
				S_BIN: begin
					bin_q <= bin_w[TB_AW-1:0];
					state_q <= bin_ok ? S_RD : S_IDLE;
				end
				S_RD: state_q <= S_WR;
				S_WR: state_q <= S_IDLE;
				S_QRD: state_q <= S_QWAIT;
				S_QWAIT: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						rsp_q.out_region <= item_q.read_region;
						rsp_q.out_bin <= item_q.read_bin;
						rsp_q.weighted_sum <= q_sum;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

### rtl/jkpb_checker.sv
module jkpb_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input jkpb_pkg::req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input jkpb_pkg::rsp_t rsp,
	input logic cfg_we,
	input logic [jkpb_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input logic [jkpb_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	// Hold a stalled response transaction
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed or dropped");

	// Go busy after any transaction that does work
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.func != jkpb_pkg::FUNC_NOP |=> req_stall)
		else $error("request channel not stalled while a transaction is in work");

	// Raise a response only at the end of a busy period
	a_rsp_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response appeared without a read in work");

endmodule

bind jackknife_marked_pair_binner_core jkpb_checker u_jkpb_checker (.*);
